### hw/rtl/bgl_pkg.sv
package bgl_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QuotBits   = 16;
    localparam logic [16:0] FactorOne  = 17'd65536;
    localparam int unsigned Lanes      = 3;

    // one vertex after classification: full means ratio is 1.0 outright
    typedef struct packed {
        logic        full;
        logic [31:0] num;
        logic [32:0] den;
    } lane_t;

    typedef struct packed {
        lane_t [Lanes-1:0] lanes;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } qitem_t;

    typedef struct packed {
        logic        full;
        logic [32:0] rem;
        logic [32:0] den;
        logic [QuotBits-1:0] quot;
    } dlane_t;

    typedef struct packed {
        dlane_t [Lanes-1:0] lanes;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } dstage_t;

    // one restoring step; remainder is always below den
    function automatic dlane_t div_step(dlane_t a);
        dlane_t      b;
        logic [33:0] r2;
        logic [33:0] d2;
        b  = a;
        r2 = {a.rem, 1'b0};
        d2 = {1'b0, a.den};
        if (r2 >= d2)
        begin
            b.rem  = 33'(r2 - d2);
            b.quot = {a.quot[QuotBits-2:0], 1'b1};
        end
        else
        begin
            b.rem  = r2[32:0];
            b.quot = {a.quot[QuotBits-2:0], 1'b0};
        end
        return b;
    endfunction

endpackage

### hw/rtl/barth_gradient_limiter.sv
// Gradient limiter for one flow variable of one triangular cell.
// Item channel: item_valid / item_stall; an item is taken on a rising edge
// with item_valid high and item_stall low. Result channel: result_valid /
// result_stall, one result beat per item, in order.
// Config channel: cfg_valid / cfg_ready carries epsilon in cfg_data; ready is
// always high, so a write lands on the edge where cfg_valid is seen.
// Throughput: one item per cycle while neither channel stalls. An item passes
// three front stages (products, vertex differences, classification), the
// queue, then the 16-step quotient pipeline (one quotient bit per stage,
// three vertices side by side), a minimum stage and the scaling multiply
// into the output register.
// The front stops (item_stall high) only when the four-beat queue is full
// and its last stage holds an item; the back stops as a whole while a result
// waits under result_stall, and the front keeps filling the queue meanwhile.
// Reset empties the pipeline and queue and sets epsilon to 1.
module barth_gradient_limiter #(
    parameter int unsigned QUEUE_DEPTH = bgl_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] center_value,
    input  logic [1:0]         neighbor_count,
    input  logic signed [31:0] neighbor_a_value,
    input  logic signed [31:0] neighbor_b_value,
    input  logic signed [31:0] neighbor_c_value,
    input  logic [47:0]        vertex_a_offset,
    input  logic [47:0]        vertex_b_offset,
    input  logic [47:0]        vertex_c_offset,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] limited_grad_x,
    output logic signed [31:0] limited_grad_y,
    output logic [16:0]        limiter_factor,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    logic [15:0] epsilon_reg;
    logic q_full, q_empty, push, pop;
    bgl_pkg::qitem_t push_item, q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epsilon_reg <= 16'd1;
        else if (cfg_valid && cfg_ready)
            epsilon_reg <= cfg_data;
    end

    bgl_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .center_value     (center_value),
        .neighbor_count   (neighbor_count),
        .neighbor_a_value (neighbor_a_value),
        .neighbor_b_value (neighbor_b_value),
        .neighbor_c_value (neighbor_c_value),
        .vertex_a_offset  (vertex_a_offset),
        .vertex_b_offset  (vertex_b_offset),
        .vertex_c_offset  (vertex_c_offset),
        .grad_x           (grad_x),
        .grad_y           (grad_y),
        .epsilon          (epsilon_reg),
        .q_full           (q_full),
        .push             (push),
        .push_item        (push_item)
    );

    bgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_item),
        .pop   (pop),
        .rdata (q_item),
        .full  (q_full),
        .empty (q_empty)
    );

    bgl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_item),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .limited_grad_x (limited_grad_x),
        .limited_grad_y (limited_grad_y),
        .limiter_factor (limiter_factor)
    );

endmodule

### hw/rtl/bgl_queue.sv
module bgl_queue #(
    parameter int unsigned DEPTH = bgl_pkg::QueueDepth
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bgl_pkg::qitem_t wdata,
    input  logic            pop,
    output bgl_pkg::qitem_t rdata,
    output logic            full,
    output logic            empty
);
    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bgl_pkg::qitem_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

### hw/rtl/bgl_front.sv
module bgl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] center_value,
    input  logic [1:0]         neighbor_count,
    input  logic signed [31:0] neighbor_a_value,
    input  logic signed [31:0] neighbor_b_value,
    input  logic signed [31:0] neighbor_c_value,
    input  logic [47:0]        vertex_a_offset,
    input  logic [47:0]        vertex_b_offset,
    input  logic [47:0]        vertex_c_offset,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    input  logic [15:0]        epsilon,
    input  logic               q_full,
    output logic               push,
    output bgl_pkg::qitem_t    push_item
);
    localparam int unsigned L = bgl_pkg::Lanes;

    logic fe;
    logic f1_v_reg, f2_v_reg, f3_v_reg;

    logic signed [31:0] lo, hi;
    logic [47:0] offs [L];

    // stage 1: min/max and products
    logic signed [31:0] c1_reg, lo1_reg, hi1_reg, gx1_reg, gy1_reg;
    logic signed [55:0] px1_reg [L];
    logic signed [55:0] py1_reg [L];

    // stage 2: vertex differences
    logic signed [31:0] gx2_reg, gy2_reg;
    logic [31:0] dhi2_reg, dlo2_reg;
    logic signed [32:0] rel2_reg [L];
    logic signed [32:0] rel_c [L];

    // stage 3: classified lanes
    bgl_pkg::qitem_t item3_reg;
    bgl_pkg::lane_t  lane_c [L];

    assign fe         = !f3_v_reg || !q_full;
    assign item_stall = !fe;
    assign push       = f3_v_reg && fe;
    assign push_item  = item3_reg;

    assign offs[0] = vertex_a_offset;
    assign offs[1] = vertex_b_offset;
    assign offs[2] = vertex_c_offset;

    always_comb
    begin
        lo = center_value;
        hi = center_value;
        if (neighbor_count != 2'd0)
        begin
            if (neighbor_a_value < lo) lo = neighbor_a_value;
            if (neighbor_a_value > hi) hi = neighbor_a_value;
        end
        if (neighbor_count >= 2'd2)
        begin
            if (neighbor_b_value < lo) lo = neighbor_b_value;
            if (neighbor_b_value > hi) hi = neighbor_b_value;
        end
        if (neighbor_count == 2'd3)
        begin
            if (neighbor_c_value < lo) lo = neighbor_c_value;
            if (neighbor_c_value > hi) hi = neighbor_c_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            logic signed [56:0] sum;
            logic signed [41:0] node;
            logic signed [31:0] nsat;
            sum  = {px1_reg[i][55], px1_reg[i]} + {py1_reg[i][55], py1_reg[i]};
            node = 42'($signed(sum[56:16])) + 42'(c1_reg);
            if (node[41] && !(&node[40:31]))
                nsat = 32'sh8000_0000;
            else if (!node[41] && (|node[40:31]))
                nsat = 32'sh7fff_ffff;
            else
                nsat = node[31:0];
            rel_c[i] = 33'(nsat) - 33'(c1_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            logic [32:0] mag;
            logic        pos;
            pos = !rel2_reg[i][32] && (rel2_reg[i] != '0);
            mag = rel2_reg[i][32] ? 33'(-rel2_reg[i]) : 33'(rel2_reg[i]);
            lane_c[i].num  = pos ? dhi2_reg : dlo2_reg;
            lane_c[i].den  = mag + 33'(epsilon);
            lane_c[i].full = (rel2_reg[i] == '0) || ({1'b0, lane_c[i].num} >= lane_c[i].den);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            c1_reg  <= center_value;
            lo1_reg <= lo;
            hi1_reg <= hi;
            gx1_reg <= grad_x;
            gy1_reg <= grad_y;
            for (int i = 0; i < L; i++)
            begin
                px1_reg[i] <= grad_x * $signed(offs[i][47:24]);
                py1_reg[i] <= grad_y * $signed(offs[i][23:0]);
            end
            gx2_reg  <= gx1_reg;
            gy2_reg  <= gy1_reg;
            dhi2_reg <= 32'(hi1_reg - c1_reg);
            dlo2_reg <= 32'(c1_reg - lo1_reg);
            for (int i = 0; i < L; i++)
                rel2_reg[i] <= rel_c[i];
            item3_reg.gx <= gx2_reg;
            item3_reg.gy <= gy2_reg;
            for (int i = 0; i < L; i++)
                item3_reg.lanes[i] <= lane_c[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_v_reg <= item_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

endmodule

### hw/rtl/bgl_back.sv
module bgl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  bgl_pkg::qitem_t    q_item,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] limited_grad_x,
    output logic signed [31:0] limited_grad_y,
    output logic [16:0]        limiter_factor
);
    localparam int unsigned L = bgl_pkg::Lanes;
    localparam int unsigned N = bgl_pkg::QuotBits;

    logic be;
    logic [N:0] dv_reg;
    bgl_pkg::dstage_t st_reg [N+1];
    bgl_pkg::dstage_t init_c;

    logic m_v_reg, o_v_reg;
    logic [16:0] ratio [L];
    logic [16:0] phi_c;
    logic [16:0] phi_reg;
    logic signed [31:0] gxm_reg, gym_reg;
    logic signed [49:0] prod_x, prod_y;
    logic signed [31:0] ox_reg, oy_reg;
    logic [16:0] of_reg;

    assign be  = !o_v_reg || !result_stall;
    assign pop = be && !q_empty;

    always_comb
    begin
        init_c.gx = q_item.gx;
        init_c.gy = q_item.gy;
        for (int i = 0; i < L; i++)
        begin
            init_c.lanes[i].full = q_item.lanes[i].full;
            init_c.lanes[i].rem  = q_item.lanes[i].full ? '0 : {1'b0, q_item.lanes[i].num};
            init_c.lanes[i].den  = q_item.lanes[i].den;
            init_c.lanes[i].quot = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
            ratio[i] = st_reg[N].lanes[i].full ? bgl_pkg::FactorOne
                                               : {1'b0, st_reg[N].lanes[i].quot};
        phi_c = (ratio[0] < ratio[1]) ? ratio[0] : ratio[1];
        if (ratio[2] < phi_c)
            phi_c = ratio[2];
    end

    assign prod_x = gxm_reg * $signed({1'b0, phi_reg});
    assign prod_y = gym_reg * $signed({1'b0, phi_reg});

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            st_reg[0] <= init_c;
            for (int s = 1; s <= N; s++)
            begin
                st_reg[s].gx <= st_reg[s-1].gx;
                st_reg[s].gy <= st_reg[s-1].gy;
                for (int i = 0; i < L; i++)
                    st_reg[s].lanes[i] <= bgl_pkg::div_step(st_reg[s-1].lanes[i]);
            end
            phi_reg <= phi_c;
            gxm_reg <= st_reg[N].gx;
            gym_reg <= st_reg[N].gy;
            // floor shift by 16, low 32 bits kept
            ox_reg  <= prod_x[47:16];
            oy_reg  <= prod_y[47:16];
            of_reg  <= phi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg  <= '0;
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (be)
        begin
            dv_reg  <= {dv_reg[N-1:0], pop};
            m_v_reg <= dv_reg[N];
            o_v_reg <= m_v_reg;
        end
    end

    assign result_valid   = o_v_reg;
    assign limited_grad_x = ox_reg;
    assign limited_grad_y = oy_reg;
    assign limiter_factor = of_reg;

endmodule

### tb/sv/barth_gradient_limiter_tb.sv
`timescale 1ns / 100ps

module barth_gradient_limiter_tb;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic [16:0]        factor;
    } limited_t;

    typedef struct {
        logic signed [31:0] center;
        logic [1:0]         count;
        logic signed [31:0] nbr [3];
        logic [47:0]        vtx [3];
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } cell_t;

    // floor(v / 65536), arithmetic shift gives floor
    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint vertex_bound(logic [47:0] off, longint c, longint lo,
                                            longint hi, longint gx, longint gy,
                                            longint eps);
        longint dx, dy, node, rel, num, den, q;
        dx = longint'($signed(off[47:24]));
        dy = longint'($signed(off[23:0]));
        node = c + floor_q16(gx * dx + gy * dy);
        if (node > 64'sd2147483647)
            node = 64'sd2147483647;
        if (node < -64'sd2147483648)
            node = -64'sd2147483648;
        rel = node - c;
        if (rel == 0)
            return 65536;
        if (rel > 0)
        begin
            num = hi - c;
            den = rel + eps;
        end
        else
        begin
            num = c - lo;
            den = eps - rel;
        end
        q = (num <<< 16) / den;
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic limited_t limit_gradient(cell_t it, logic [15:0] eps);
        longint   c, lo, hi, n, r, phi;
        limited_t res;
        c = longint'(it.center);
        lo = c;
        hi = c;
        phi = 65536;
        for (int i = 0; i < 3; i++)
        begin
            if (i < it.count)
            begin
                n = longint'(it.nbr[i]);
                if (n < lo) lo = n;
                if (n > hi) hi = n;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r = vertex_bound(it.vtx[i], c, lo, hi, longint'(it.gx), longint'(it.gy),
                             longint'(eps));
            if (r < phi) phi = r;
        end
        res.gx = 32'(floor_q16(longint'(it.gx) * phi));
        res.gy = 32'(floor_q16(longint'(it.gy) * phi));
        res.factor = 17'(phi);
        return res;
    endfunction

    class gradient_scoreboard;
        limited_t pending[$];
        int       mismatches;
        logic [15:0] epsilon;

        function new();
            mismatches = 0;
            epsilon = 16'd1;
        endfunction

        function void note_cell(cell_t it);
            pending.push_back(limit_gradient(it, epsilon));
        endfunction

        function void check_result(limited_t got);
            limited_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat gx=%0d gy=%0d f=%0d",
                             got.gx, got.gy, got.factor);
                return;
            end
            want = pending.pop_front();
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp gx=%0d gy=%0d f=%0d, got gx=%0d gy=%0d f=%0d",
                             want.gx, want.gy, want.factor, got.gx, got.gy, got.factor);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [31:0] center_value;
    logic [1:0]         neighbor_count;
    logic signed [31:0] neighbor_a_value;
    logic signed [31:0] neighbor_b_value;
    logic signed [31:0] neighbor_c_value;
    logic [47:0]        vertex_a_offset;
    logic [47:0]        vertex_b_offset;
    logic [47:0]        vertex_c_offset;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] limited_grad_x;
    logic signed [31:0] limited_grad_y;
    logic [16:0]        limiter_factor;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    gradient_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles = 0;

    barth_gradient_limiter u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .center_value     (center_value),
        .neighbor_count   (neighbor_count),
        .neighbor_a_value (neighbor_a_value),
        .neighbor_b_value (neighbor_b_value),
        .neighbor_c_value (neighbor_c_value),
        .vertex_a_offset  (vertex_a_offset),
        .vertex_b_offset  (vertex_b_offset),
        .vertex_c_offset  (vertex_c_offset),
        .grad_x           (grad_x),
        .grad_y           (grad_y),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .limited_grad_x   (limited_grad_x),
        .limited_grad_y   (limited_grad_y),
        .limiter_factor   (limiter_factor),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stall, check each accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(limited_t'{limited_grad_x, limited_grad_y, limiter_factor});
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_cell(cell_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid       <= 1'b1;
        center_value     <= it.center;
        neighbor_count   <= it.count;
        neighbor_a_value <= it.nbr[0];
        neighbor_b_value <= it.nbr[1];
        neighbor_c_value <= it.nbr[2];
        vertex_a_offset  <= it.vtx[0];
        vertex_b_offset  <= it.vtx[1];
        vertex_c_offset  <= it.vtx[2];
        grad_x           <= it.gx;
        grad_y           <= it.gy;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_cell(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.epsilon = value;
    endtask

    // offsets kept modest most of the time so ratios land inside (0,1)
    function automatic logic [47:0] rand_offset();
        logic [23:0] dx, dy;
        if ($urandom_range(3) == 0)
            return {$urandom(), $urandom()};
        dx = 24'($signed($urandom_range(262143)) - 131072);
        dy = 24'($signed($urandom_range(262143)) - 131072);
        return {dx, dy};
    endfunction

    function automatic logic signed [31:0] rand_value();
        if ($urandom_range(2) == 0)
            return $urandom();
        return 32'($signed($urandom_range(2097151)) - 1048576);
    endfunction

    function automatic cell_t rand_cell();
        cell_t it;
        it.center = rand_value();
        it.count  = $urandom_range(3);
        for (int i = 0; i < 3; i++)
        begin
            it.nbr[i] = ($urandom_range(4) == 0) ? $urandom() : it.center + rand_value() / 4;
            it.vtx[i] = rand_offset();
        end
        it.gx = rand_value();
        it.gy = rand_value();
        return it;
    endfunction

    task automatic run_directed();
        cell_t it;
        for (int k = 0; k < 20; k++)
        begin
            it = rand_cell();
            case (k)
                0: begin it.gx = 0; it.gy = 0; end
                1: it.count = 2'd0;
                2: begin it.center = 32'h7FFF_FFFF; it.gx = 32'h7FFF_FFFF;
                         it.vtx[0] = {24'h7FFFFF, 24'h7FFFFF}; end
                3: begin it.center = 32'h8000_0000; it.gx = 32'h7FFF_FFFF;
                         it.vtx[0] = {24'h800000, 24'h800000}; it.gy = 32'h8000_0000; end
                4: begin it.count = 2'd3; it.nbr[0] = 32'h8000_0000;
                         it.nbr[1] = 32'h7FFF_FFFF; it.nbr[2] = 0; end
                5: begin it.vtx[0] = '1; it.vtx[1] = '0; it.vtx[2] = '1; end
                6: begin it.count = 2'd1; it.nbr[0] = it.center; end
                7: begin it.gx = 32'h8000_0000; it.gy = 32'h8000_0000; end
                8: begin it.gx = 32'h0000_0001; it.gy = 32'hFFFF_FFFF; end
                default: ;
            endcase
            send_cell(it);
        end
    endtask

    initial
    begin
        logic [15:0] eps_set [5];
        int phase_idle [4];
        int phase_stall [4];
        eps_set = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd7};
        phase_idle = '{0, 70, 0, 21};
        phase_stall = '{0, 0, 70, 21};
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        center_value = '0;
        neighbor_count = '0;
        neighbor_a_value = '0;
        neighbor_b_value = '0;
        neighbor_c_value = '0;
        vertex_a_offset = '0;
        vertex_b_offset = '0;
        vertex_c_offset = '0;
        grad_x = '0;
        grad_y = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset epsilon first
        run_directed();
        drain();
        for (int p = 0; p < 5; p++)
        begin
            write_epsilon(eps_set[p]);
            if (p == 0)
                run_directed();
            for (int ph = 0; ph < 4; ph++)
            begin
                send_idle_pct = phase_idle[ph];
                stall_pct = phase_stall[ph];
                for (int n = 0; n < 40; n++)
                    send_cell(rand_cell());
            end
            send_idle_pct = 0;
            stall_pct = 0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bgl_pkg.sv
hw/rtl/bgl_queue.sv
hw/rtl/bgl_front.sv
hw/rtl/bgl_back.sv
hw/rtl/barth_gradient_limiter.sv
tb/sv/barth_gradient_limiter_tb.sv
